@@ hdl/uflc_pkg.sv @@
// ----------------------------------------------------------------------------
// uflc_pkg: shared definitions for the UART flash loader command sequencer
// Command codes, received command characters and the command batch that one
// received byte produces.
// ----------------------------------------------------------------------------
package uflc_pkg;

	localparam int unsigned PageBytesDefault = 256;
	localparam int unsigned FillW            = 9;
	localparam int unsigned MaxCmds          = 5;
	localparam int unsigned CntW             = 3;

	typedef enum logic [3:0] {
		OP_RESET_ASSERT  = 4'd0,
		OP_RESET_RELEASE = 4'd1,
		OP_WAKE_FLASH    = 4'd2,
		OP_FLOAT_PULSE   = 4'd3,
		OP_ENTER_BOOT    = 4'd4,
		OP_SEND_VERSION  = 4'd5,
		OP_ERASE         = 4'd6,
		OP_WRITE_ENABLE  = 4'd7,
		OP_START_WRITE   = 4'd8,
		OP_WRITE_BYTE    = 4'd9,
		OP_PAGE_WAIT     = 4'd10,
		OP_READ_BURST    = 4'd11,
		OP_FINISH_WRITE  = 4'd12
	} op_t;

	localparam logic [7:0] CH_WRITE   = 8'h57; // 'W'
	localparam logic [7:0] CH_READ    = 8'h52; // 'R'
	localparam logic [7:0] CH_RELEASE = 8'h44; // 'D'
	localparam logic [7:0] CH_FLOAT   = 8'h41; // 'A'
	localparam logic [7:0] CH_BOOT    = 8'h42; // 'B'
	localparam logic [7:0] CH_VERSION = 8'h56; // 'V'

	// Commands of one received byte. Address, data and count are each used by
	// at most one command of the batch, so one copy of each is enough.
	typedef struct packed {
		logic [CntW-1:0]         cnt;
		logic [MaxCmds-1:0][3:0] ops;
		logic [31:0]             addr;
		logic [7:0]              data;
		logic [31:0]             count;
	} batch_t;

endpackage

@@ hdl/uflc_seq.sv @@
// ----------------------------------------------------------------------------
// uflc_seq: loader state machine
// Holds the transfer state and decodes each received byte into its batch of
// flash commands; the state advances on every accepted transfer.
// ----------------------------------------------------------------------------
module uflc_seq #(
	parameter int unsigned PAGE_BYTES = uflc_pkg::PageBytesDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       rx_byte,
	output uflc_pkg::batch_t batch
);

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_LEN1  = 6'b000010,
		PH_LEN2  = 6'b000100,
		PH_LEN3  = 6'b001000,
		PH_LEN4  = 6'b010000,
		PH_WRITE = 6'b100000
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic                       is_write_q, is_write_d;
	logic [31:0]                remaining_q, remaining_d;
	logic [31:0]                page_base_q, page_base_d;
	logic [uflc_pkg::FillW-1:0] page_fill_q, page_fill_d;

	logic [31:0]                rem_dec;
	logic [uflc_pkg::FillW-1:0] fill_inc;
	logic [31:0]                base_inc;
	logic                       page_done;
	logic                       count_done;

	assign rem_dec    = remaining_q - 32'd1;
	assign fill_inc   = page_fill_q + {{(uflc_pkg::FillW-1){1'b0}}, 1'b1};
	assign base_inc   = page_base_q + 32'(PAGE_BYTES);
	assign page_done  = (fill_inc == uflc_pkg::FillW'(PAGE_BYTES));
	assign count_done = (rem_dec == 32'd0);

	always_comb begin
		phase_d     = phase_q;
		is_write_d  = is_write_q;
		remaining_d = remaining_q;
		page_base_d = page_base_q;
		page_fill_d = page_fill_q;
		batch       = '0;

		case (phase_q)
			PH_LEN1: begin
				remaining_d[7:0] = rx_byte;
				phase_d          = PH_LEN2;
			end
			PH_LEN2: begin
				remaining_d[15:8] = rx_byte;
				phase_d           = PH_LEN3;
			end
			PH_LEN3: begin
				remaining_d[23:16] = rx_byte;
				phase_d            = PH_LEN4;
			end
			PH_LEN4: begin
				if (is_write_q) begin
					remaining_d[31:24] = rx_byte;
					page_base_d        = '0;
					page_fill_d        = '0;
					phase_d            = PH_WRITE;
					batch.cnt          = uflc_pkg::CntW'(3);
					batch.ops[0]       = uflc_pkg::OP_ERASE;
					batch.ops[1]       = uflc_pkg::OP_WRITE_ENABLE;
					batch.ops[2]       = uflc_pkg::OP_START_WRITE;
				end else begin
					batch.count  = {rx_byte, remaining_q[23:0]};
					remaining_d  = '0;
					page_fill_d  = '0;
					phase_d      = PH_IDLE;
					batch.cnt    = uflc_pkg::CntW'(1);
					batch.ops[0] = uflc_pkg::OP_READ_BURST;
				end
			end
			PH_WRITE: begin
				remaining_d  = rem_dec;
				page_fill_d  = fill_inc;
				batch.data   = rx_byte;
				batch.ops[0] = uflc_pkg::OP_WRITE_BYTE;
				batch.cnt    = uflc_pkg::CntW'(1);
				if (page_done) begin
					page_fill_d  = '0;
					page_base_d  = base_inc;
					batch.addr   = base_inc;
					batch.ops[1] = uflc_pkg::OP_PAGE_WAIT;
					batch.ops[2] = uflc_pkg::OP_WRITE_ENABLE;
					batch.ops[3] = uflc_pkg::OP_START_WRITE;
					batch.cnt    = uflc_pkg::CntW'(4);
				end
				if (count_done) begin
					phase_d = PH_IDLE;
					if (page_done) begin
						batch.ops[4] = uflc_pkg::OP_FINISH_WRITE;
						batch.cnt    = uflc_pkg::CntW'(5);
					end else begin
						batch.ops[1] = uflc_pkg::OP_FINISH_WRITE;
						batch.cnt    = uflc_pkg::CntW'(2);
					end
				end
			end
			default: begin
				// Idle; any unexpected phase code is treated the same way.
				phase_d = PH_IDLE;
				if (rx_byte inside {uflc_pkg::CH_WRITE, uflc_pkg::CH_READ}) begin
					is_write_d   = (rx_byte == uflc_pkg::CH_WRITE);
					remaining_d  = '0;
					phase_d      = PH_LEN1;
					batch.cnt    = uflc_pkg::CntW'(2);
					batch.ops[0] = uflc_pkg::OP_RESET_ASSERT;
					batch.ops[1] = uflc_pkg::OP_WAKE_FLASH;
				end else if (rx_byte == uflc_pkg::CH_RELEASE) begin
					batch.cnt    = uflc_pkg::CntW'(1);
					batch.ops[0] = uflc_pkg::OP_RESET_RELEASE;
				end else if (rx_byte == uflc_pkg::CH_FLOAT) begin
					batch.cnt    = uflc_pkg::CntW'(1);
					batch.ops[0] = uflc_pkg::OP_FLOAT_PULSE;
				end else if (rx_byte == uflc_pkg::CH_BOOT) begin
					batch.cnt    = uflc_pkg::CntW'(1);
					batch.ops[0] = uflc_pkg::OP_ENTER_BOOT;
				end else if (rx_byte == uflc_pkg::CH_VERSION) begin
					batch.cnt    = uflc_pkg::CntW'(1);
					batch.ops[0] = uflc_pkg::OP_SEND_VERSION;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			is_write_q  <= 1'b0;
			remaining_q <= '0;
			page_base_q <= '0;
			page_fill_q <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			is_write_q  <= is_write_d;
			remaining_q <= remaining_d;
			page_base_q <= page_base_d;
			page_fill_q <= page_fill_d;
		end
	end

endmodule

@@ hdl/uflc_out.sv @@
// ----------------------------------------------------------------------------
// uflc_out: command batch register and output serializer
// Holds the batch of the last received byte and hands its commands out one
// transfer at a time; a new batch loads as the last command leaves.
// ----------------------------------------------------------------------------
module uflc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  uflc_pkg::batch_t batch,
	output logic             load_ok,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [3:0]       op,
	output logic [31:0]      flash_address,
	output logic [7:0]       payload,
	output logic [31:0]      burst_count,
	output logic             last
);

	uflc_pkg::batch_t          batch_q;
	logic                      busy_q;
	logic [uflc_pkg::CntW-1:0] idx_q;
	logic                      is_last;
	logic                      done;

	assign is_last = (idx_q == batch_q.cnt - uflc_pkg::CntW'(1));
	assign done    = busy_q && !out_stall && is_last;
	assign load_ok = !busy_q || done;

	assign out_valid     = busy_q;
	assign op            = batch_q.ops[idx_q];
	assign last          = is_last;
	assign flash_address = (op == uflc_pkg::OP_START_WRITE) ? batch_q.addr : '0;
	assign payload       = (op == uflc_pkg::OP_WRITE_BYTE) ? batch_q.data : '0;
	assign burst_count   = (op == uflc_pkg::OP_READ_BURST) ? batch_q.count : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take && batch.cnt != '0) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q && !out_stall) begin
			idx_q <= idx_q + uflc_pkg::CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			batch_q <= batch;
		end
	end

endmodule

@@ hdl/uart_flash_loader_command_fsm_top.sv @@
// ----------------------------------------------------------------------------
// uart_flash_loader_command_fsm_top: UART flash loader command sequencer
// Turns received serial bytes into a stream of flash-programming commands.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   rx_byte
//   output   out        out_valid/out_stall op, flash_address, payload,
//                                           burst_count, last
//
// A received byte is decoded in the cycle it is taken and its commands
// (zero to five) are registered; they leave one per cycle while out_stall
// is low, from the next cycle on.
// The next byte is taken in the cycle the last command of the batch leaves.
// Reset returns the sequencer to idle with an empty command register.
// ----------------------------------------------------------------------------
module uart_flash_loader_command_fsm_top #(
	parameter int unsigned PAGE_BYTES = uflc_pkg::PageBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  op,
	output logic [31:0] flash_address,
	output logic [7:0]  payload,
	output logic [31:0] burst_count,
	output logic        last
);

	uflc_pkg::batch_t batch;
	logic             load_ok;
	logic             take;

	assign in_stall = !load_ok;
	assign take     = in_valid && load_ok;

	uflc_seq #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.batch   (batch)
	);

	uflc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.batch         (batch),
		.load_ok       (load_ok),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.op            (op),
		.flash_address (flash_address),
		.payload       (payload),
		.burst_count   (burst_count),
		.last          (last)
	);

endmodule

@@ test/uart_flash_loader_command_fsm_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_flash_loader_command_fsm_top_test: command sequencer testbench
// Feeds received bytes through the input channel and predicts the command
// stream that each byte causes. Every command that leaves the output channel
// is checked field by field against the oldest prediction. The sender works
// in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module uart_flash_loader_command_fsm_top_test;

	localparam int unsigned PAGE_BYTES = uflc_pkg::PageBytesDefault;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEN1  = 3'd1,
		PH_LEN2  = 3'd2,
		PH_LEN3  = 3'd3,
		PH_LEN4  = 3'd4,
		PH_WRITE = 3'd5
	} phase_t;

	typedef struct {
		uflc_pkg::op_t op;
		logic [31:0]   addr;
		logic [7:0]    data;
		logic [31:0]   count;
		logic          last;
	} cmd_t;

	typedef struct {
		logic [7:0] b;
		bit         drain;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  op;
	logic [31:0] flash_address;
	logic [7:0]  payload;
	logic [31:0] burst_count;
	logic        last;

	// Predictor state.
	phase_t      seq_phase = PH_IDLE;
	logic        seq_is_write = 1'b0;
	logic [31:0] seq_remaining = '0;
	logic [31:0] seq_page_base = '0;
	logic [8:0]  seq_page_fill = '0;

	cmd_t     cmd_expect[$];
	rx_item_t byte_queue[$];
	cmd_t     cmd_want;

	int errors = 0;
	int bytes_sent = 0;
	int cmds_checked = 0;
	int rearms_seen = 0;
	int bursts_seen = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_span = 0;
	int stall_mode = 0;

	uart_flash_loader_command_fsm_top #(.PAGE_BYTES(PAGE_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.op(op),
		.flash_address(flash_address),
		.payload(payload),
		.burst_count(burst_count),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic cmd_t make_cmd(uflc_pkg::op_t o, logic [31:0] a = '0,
			logic [7:0] d = '0, logic [31:0] c = '0);
		cmd_t r;
		r.op = o;
		r.addr = a;
		r.data = d;
		r.count = c;
		r.last = 1'b0;
		return r;
	endfunction

	// Advances the predicted sequencer by one received byte and queues the
	// commands it causes.
	function automatic void sequence_byte(logic [7:0] b);
		cmd_t batch[$];
		case (seq_phase)
			PH_LEN1, PH_LEN2, PH_LEN3: begin
				seq_remaining |= 32'(b) << (8 * (int'(seq_phase) - 1));
				seq_phase = phase_t'(seq_phase + 3'd1);
			end
			PH_LEN4: begin
				seq_remaining |= 32'(b) << 24;
				if (seq_is_write) begin
					batch.push_back(make_cmd(uflc_pkg::OP_ERASE));
					batch.push_back(make_cmd(uflc_pkg::OP_WRITE_ENABLE));
					seq_page_base = '0;
					seq_page_fill = '0;
					batch.push_back(make_cmd(uflc_pkg::OP_START_WRITE, seq_page_base));
					seq_phase = PH_WRITE;
				end else begin
					batch.push_back(make_cmd(uflc_pkg::OP_READ_BURST, '0, '0,
						seq_remaining));
					seq_remaining = '0;
					seq_page_fill = '0;
					seq_phase = PH_IDLE;
				end
			end
			PH_WRITE: begin
				batch.push_back(make_cmd(uflc_pkg::OP_WRITE_BYTE, '0, b));
				seq_page_fill = seq_page_fill + 9'd1;
				seq_remaining = seq_remaining - 32'd1;
				if (seq_page_fill == 9'(PAGE_BYTES)) begin
					batch.push_back(make_cmd(uflc_pkg::OP_PAGE_WAIT));
					batch.push_back(make_cmd(uflc_pkg::OP_WRITE_ENABLE));
					seq_page_fill = '0;
					seq_page_base = seq_page_base + 32'(PAGE_BYTES);
					batch.push_back(make_cmd(uflc_pkg::OP_START_WRITE, seq_page_base));
				end
				if (seq_remaining == '0) begin
					batch.push_back(make_cmd(uflc_pkg::OP_FINISH_WRITE));
					seq_phase = PH_IDLE;
				end
			end
			default: begin
				// The unused phase codes behave as idle.
				if (b inside {uflc_pkg::CH_WRITE, uflc_pkg::CH_READ}) begin
					seq_is_write = (b == uflc_pkg::CH_WRITE);
					seq_remaining = '0;
					seq_phase = PH_LEN1;
					batch.push_back(make_cmd(uflc_pkg::OP_RESET_ASSERT));
					batch.push_back(make_cmd(uflc_pkg::OP_WAKE_FLASH));
				end else begin
					seq_phase = PH_IDLE;
					if (b == uflc_pkg::CH_RELEASE)
						batch.push_back(make_cmd(uflc_pkg::OP_RESET_RELEASE));
					else if (b == uflc_pkg::CH_FLOAT)
						batch.push_back(make_cmd(uflc_pkg::OP_FLOAT_PULSE));
					else if (b == uflc_pkg::CH_BOOT)
						batch.push_back(make_cmd(uflc_pkg::OP_ENTER_BOOT));
					else if (b == uflc_pkg::CH_VERSION)
						batch.push_back(make_cmd(uflc_pkg::OP_SEND_VERSION));
				end
			end
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			cmd_expect.push_back(batch[i]);
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
		errors++;
	endtask

	task automatic push_byte(logic [7:0] b, bit drain = 1'b0);
		rx_item_t it;
		it.b = b;
		it.drain = drain;
		byte_queue.push_back(it);
	endtask

	task automatic push_len(logic [31:0] len);
		for (int i = 0; i < 4; i++)
			push_byte(len[8*i +: 8]);
	endtask

	task automatic push_read(logic [31:0] len, bit drain = 1'b0);
		push_byte(uflc_pkg::CH_READ, drain);
		push_len(len);
	endtask

	task automatic push_write(logic [31:0] len, int nbytes, bit drain = 1'b0);
		push_byte(uflc_pkg::CH_WRITE, drain);
		push_len(len);
		for (int i = 0; i < nbytes; i++)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall) begin
				sequence_byte(rx_byte);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (byte_queue.size() == 0 ||
						(byte_queue[0].drain && cmd_expect.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					rx_byte <= byte_queue[0].b;
					void'(byte_queue.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Receiver: checks each transfer and stalls in changing modes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cmd_expect.size() == 0) begin
					report_mismatch("unexpected command, op", 32'(op), '0);
				end else begin
					cmd_want = cmd_expect.pop_front();
					cmds_checked++;
					if (op !== cmd_want.op)
						report_mismatch("op", 32'(op), 32'(cmd_want.op));
					if (flash_address !== cmd_want.addr)
						report_mismatch("flash_address", flash_address, cmd_want.addr);
					if (payload !== cmd_want.data)
						report_mismatch("payload", 32'(payload), 32'(cmd_want.data));
					if (burst_count !== cmd_want.count)
						report_mismatch("burst_count", burst_count, cmd_want.count);
					if (last !== cmd_want.last)
						report_mismatch("last", 32'(last), 32'(cmd_want.last));
					if (cmd_want.op == uflc_pkg::OP_PAGE_WAIT)
						rearms_seen++;
					if (cmd_want.op == uflc_pkg::OP_READ_BURST)
						bursts_seen++;
				end
			end
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_span = $urandom_range(10, 60);
			end else begin
				stall_span--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= (stall_span % 4 != 0);
			endcase
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int          random_items;
		int          sel;
		int          len;
		bit          drain;
		bit          long_done;
		logic [7:0]  b;

		random_items = 0;
		long_done = 1'b0;

		// Directed: single actions, read extremes, shortest writes.
		push_byte(uflc_pkg::CH_RELEASE);
		push_byte(uflc_pkg::CH_FLOAT);
		push_byte(uflc_pkg::CH_BOOT);
		push_byte(uflc_pkg::CH_VERSION);
		push_read(32'h0000_0000);
		push_read(32'hFFFF_FFFF, 1'b1);
		push_byte(uflc_pkg::CH_WRITE);
		push_len(32'd1);
		push_byte(8'h00);
		push_byte(uflc_pkg::CH_WRITE, 1'b1);
		push_len(32'd1);
		push_byte(8'hFF);

		// Random: mostly well-formed transfers with random content.
		while (random_items < 250) begin
			sel = $urandom_range(0, 99);
			drain = ($urandom_range(0, 19) == 0);
			if (sel < 35) begin
				// One write ends exactly on a page boundary.
				if (!long_done && random_items > 10) begin
					len = PAGE_BYTES;
					long_done = 1'b1;
				end else begin
					len = $urandom_range(1, 12);
				end
				push_write(len, len, drain);
				random_items += len + 5;
			end else if (sel < 55) begin
				push_read($urandom_range(0, 1) ? $urandom : $urandom_range(0, 300), drain);
				random_items += 5;
			end else if (sel < 80) begin
				case ($urandom_range(0, 3))
					0: push_byte(uflc_pkg::CH_RELEASE, drain);
					1: push_byte(uflc_pkg::CH_FLOAT, drain);
					2: push_byte(uflc_pkg::CH_BOOT, drain);
					default: push_byte(uflc_pkg::CH_VERSION, drain);
				endcase
				random_items++;
			end else begin
				// Noise in idle; transfer starts are left to the sequences above.
				do
					b = 8'($urandom_range(0, 255));
				while (b inside {uflc_pkg::CH_WRITE, uflc_pkg::CH_READ});
				push_byte(b, drain);
				random_items++;
			end
		end
		if (!long_done)
			push_write(PAGE_BYTES, PAGE_BYTES);

		// A zero length wraps around, so this write never finishes; it goes
		// last.
		push_write(32'd0, 3, 1'b1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || in_valid || cmd_expect.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes and checked %0d commands under random stalls,",
			bytes_sent, cmds_checked);
		$display("including %0d page re-arms and %0d read bursts.", rearms_seen, bursts_seen);
		if (errors == 0 && cmd_expect.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
